@@ hw/rtl/bpjq_pkg.sv @@
// Package for the bounded priority job queue: operation codes, job entry,
// channel beat types, controller states and the controller/datapath bundles.
// Has no dependencies; every other file of the block but bpjq_ram uses it.
`default_nettype none

package bpjq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DONE = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef struct packed {
    logic [3:0]  prio;
    logic [3:0]  ctime;
    logic [7:0]  prod;
    logic [16:0] id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  job_priority;
    logic [3:0]  job_compute_time;
    logic [7:0]  producer_number;
    logic [16:0] job_identifier;
  } in_item_t;

  typedef struct packed {
    logic        push_accepted;
    logic        job_valid;
    logic        quota_done;
    logic [3:0]  out_priority;
    logic [3:0]  out_compute_time;
    logic [7:0]  out_producer;
    logic [16:0] out_job_id;
    logic [3:0]  occupancy;
    logic [15:0] created_count;
    logic [15:0] completed_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_SHIFT_SETUP,
    ST_SHIFT,
    ST_SHIFT_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic scan_init;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic pop_go;
    logic scan_end;
    logic shift_none;
    logic shift_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpjq_if.sv @@
// Channel interfaces for the job queue: one for input beats, one for results.
// Depends on bpjq_pkg for the beat types.
`default_nettype none

interface bpjq_in_if;
  logic               valid;
  logic               ready;
  bpjq_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bpjq_out_if;
  logic                valid;
  logic                ready;
  bpjq_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bpjq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bpjq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpjq_ctrl.sv @@
// Controller state machine of the job queue: sequences capture, the priority
// scan, the compaction pass and the commit. Depends on bpjq_pkg.
`default_nettype none

module bpjq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bpjq_pkg::sts_t sts_i,
  output bpjq_pkg::cmd_t      cmd_o
);

  bpjq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpjq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bpjq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = bpjq_pkg::ST_EXEC;
        end
      end
      bpjq_pkg::ST_EXEC: begin
        if (sts_i.pop_go) begin
          cmd_o.scan_init = 1'b1;
          state_d         = bpjq_pkg::ST_SCAN;
        end else begin
          state_d = bpjq_pkg::ST_FINISH;
        end
      end
      bpjq_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_end) begin
          state_d = bpjq_pkg::ST_SCAN_DRAIN;
        end
      end
      bpjq_pkg::ST_SCAN_DRAIN: begin
        state_d = bpjq_pkg::ST_SHIFT_SETUP;
      end
      bpjq_pkg::ST_SHIFT_SETUP: begin
        cmd_o.shift_init = 1'b1;
        state_d = sts_i.shift_none ? bpjq_pkg::ST_FINISH : bpjq_pkg::ST_SHIFT;
      end
      bpjq_pkg::ST_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (sts_i.shift_end) begin
          state_d = bpjq_pkg::ST_SHIFT_DRAIN;
        end
      end
      bpjq_pkg::ST_SHIFT_DRAIN: begin
        state_d = bpjq_pkg::ST_FINISH;
      end
      bpjq_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bpjq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpjq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpjq_dp.sv @@
// Datapath of the job queue: counters, quota, captured beat, scan and
// compaction pointers, entry RAM port control and the result register.
// Depends on bpjq_pkg; drives a bpjq_ram instance at the top level.
`default_nettype none

module bpjq_dp #(
  parameter int unsigned QUEUE_DEPTH = 8,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire bpjq_pkg::in_item_t   in_item_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output bpjq_pkg::out_item_t       out_item_o,
  input  wire bpjq_pkg::cmd_t       cmd_i,
  output bpjq_pkg::sts_t            sts_o,
  output logic                      ram_we_o,
  output logic [IdxW-1:0]           ram_waddr_o,
  output logic [bpjq_pkg::EntryW-1:0] ram_wdata_o,
  output logic [IdxW-1:0]           ram_raddr_o,
  input  wire logic [bpjq_pkg::EntryW-1:0] ram_rdata_i
);

  logic [15:0]         quota_q, created_q, created_d, completed_q, completed_d;
  logic [CntW-1:0]     count_q, count_d;
  bpjq_pkg::in_item_t  item_q;
  logic [IdxW-1:0]     ptr_q, ptr_d;
  logic                cmp_vld_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic [IdxW-1:0]     best_idx_q;
  bpjq_pkg::entry_t    best_q;
  logic                wr_vld_q;
  logic [IdxW-1:0]     wr_idx_q;
  logic                out_valid_q;
  bpjq_pkg::out_item_t out_q, out_d;
  bpjq_pkg::entry_t    rd_entry, push_entry;
  bpjq_pkg::op_e       op;
  logic [CntW-1:0]     last_idx, best_nxt;
  logic [CntW+3:0]     occ_ext;
  logic                created_at_quota, completed_at_quota, push_ok;
  logic [15:0]         created_inc, completed_inc;

  assign op         = bpjq_pkg::op_e'(item_q.operation);
  assign rd_entry   = bpjq_pkg::entry_t'(ram_rdata_i);
  assign push_entry = '{prio: item_q.job_priority, ctime: item_q.job_compute_time,
                        prod: item_q.producer_number, id: item_q.job_identifier};

  assign created_at_quota   = created_q >= quota_q;
  assign completed_at_quota = completed_q >= quota_q;
  assign push_ok     = !created_at_quota && (count_q < CntW'(QUEUE_DEPTH));
  assign created_inc   = created_q + 16'd1;
  assign completed_inc = completed_q + 16'd1;

  assign last_idx = count_q - CntW'(1);
  assign best_nxt = CntW'(best_idx_q) + CntW'(1);

  assign sts_o.pop_go     = (op == bpjq_pkg::OP_POP) && !completed_at_quota &&
                            (count_q != '0);
  assign sts_o.scan_end   = CntW'(ptr_q) == last_idx;
  assign sts_o.shift_none = best_nxt == count_q;
  assign sts_o.shift_end  = CntW'(ptr_q) == last_idx;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign ram_raddr_o = ptr_q;
  assign ram_we_o    = wr_vld_q || (cmd_i.commit && (op == bpjq_pkg::OP_PUSH) && push_ok);
  assign ram_waddr_o = wr_vld_q ? wr_idx_q : count_q[IdxW-1:0];
  assign ram_wdata_o = wr_vld_q ? ram_rdata_i : push_entry;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.scan_init) begin
      ptr_d = '0;
    end else if (cmd_i.shift_init) begin
      ptr_d = best_idx_q + 1'b1;
    end else if (cmd_i.scan_rd || cmd_i.shift_rd) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_comb begin
    count_d     = count_q;
    created_d   = created_q;
    completed_d = completed_q;
    out_d       = '0;
    case (op)
      bpjq_pkg::OP_PUSH: begin
        if (created_at_quota) begin
          out_d.quota_done = 1'b1;
        end else if (push_ok) begin
          count_d             = count_q + CntW'(1);
          created_d           = created_inc;
          out_d.push_accepted = 1'b1;
          out_d.quota_done    = created_inc >= quota_q;
        end
      end
      bpjq_pkg::OP_POP: begin
        if (completed_at_quota) begin
          out_d.quota_done = 1'b1;
        end else if (count_q != '0) begin
          count_d                = count_q - CntW'(1);
          out_d.job_valid        = 1'b1;
          out_d.out_priority     = best_q.prio;
          out_d.out_compute_time = best_q.ctime;
          out_d.out_producer     = best_q.prod;
          out_d.out_job_id       = best_q.id;
        end
      end
      bpjq_pkg::OP_DONE: begin
        if (completed_at_quota) begin
          out_d.quota_done = 1'b1;
        end else begin
          completed_d      = completed_inc;
          out_d.quota_done = completed_inc >= quota_q;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
    occ_ext               = {4'b0, count_d};
    out_d.occupancy       = occ_ext[3:0];
    out_d.created_count   = created_d;
    out_d.completed_count = completed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q     <= '0;
      created_q   <= '0;
      completed_q <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quota_q <= cfg_wdata_i;
      end
      cmp_vld_q <= cmd_i.scan_rd;
      wr_vld_q  <= cmd_i.shift_rd;
      if (cmd_i.commit) begin
        created_q   <= created_d;
        completed_q <= completed_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    cmp_idx_q <= ptr_q;
    wr_idx_q  <= ptr_q - 1'b1;
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmp_vld_q && ((cmp_idx_q == '0) || (rd_entry.prio > best_q.prio))) begin
      best_q     <= rd_entry;
      best_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/bounded_priority_job_queue_unit.sv @@
// Top level of the bounded priority job queue: controller, datapath and the
// entry RAM. Depends on bpjq_pkg, bpjq_if, bpjq_ram, bpjq_ctrl and bpjq_dp.
//
//   Channel   Direction  Beat              Handshake
//   in_i      sink       operation + job   valid/ready
//   out_o     source     one result        valid/ready
//   cfg       input      job_quota         cfg_we_i, no wait
//
// Push, completion, no-op and non-removing pop beats go from capture through execute to commit.
// A pop that removes a job also scans all occupied entries, one entry per cycle, and then
// moves the entries behind the removed job up, one per cycle; the move is skipped
// when the removed job is the newest entry.
// Reset clears the counters, the quota and the occupancy; the RAM is not cleared.
// One beat is in work at a time; a result waiting on out_o holds only the commit.
`default_nettype none

module bounded_priority_job_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  bpjq_in_if.sink    in_i,
  bpjq_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  bpjq_pkg::cmd_t              cmd;
  bpjq_pkg::sts_t              sts;
  logic                        ram_we;
  logic [IdxW-1:0]             ram_waddr, ram_raddr;
  logic [bpjq_pkg::EntryW-1:0] ram_wdata, ram_rdata;

  bpjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_i.payload),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bpjq_ram #(
    .WIDTH (bpjq_pkg::EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bounded_priority_job_queue_unit: a driver and a
// monitor on the beat channels, checked against a priority queue predictor.
// Depends on bpjq_pkg, bpjq_if and the RTL of the job queue.
`timescale 1ns / 100ps

module testbench;
  import bpjq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned BEATS_PER_PHASE = 128;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  bpjq_in_if  in_bus ();
  bpjq_out_if out_bus ();

  bounded_priority_job_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  entry_t      job_store [QUEUE_DEPTH];
  int          queue_fill = 0;
  logic [15:0] jobs_created = '0;
  logic [15:0] jobs_completed = '0;
  logic [15:0] job_quota = '0;

  in_item_t    pending_beats [$];
  out_item_t   expected_results [$];
  out_item_t   oldest_result;
  int          error_count = 0;
  int          send_gap = 0;
  int          sink_stall = 0;
  int          source_calm = 0;
  int          sink_calm = 0;
  int          idle_cycles = 0;
  logic        drain_hold = 1'b0;

  always #5 clk = ~clk;

  function automatic out_item_t schedule_job_step(in_item_t beat);
    out_item_t res;
    int        best;
    int        idx;
    res = '0;
    case (op_e'(beat.operation))
      OP_PUSH: begin
        if (jobs_created >= job_quota) begin
          res.quota_done = 1'b1;
        end else if (queue_fill < QUEUE_DEPTH) begin
          job_store[queue_fill] = '{beat.job_priority, beat.job_compute_time,
                                    beat.producer_number, beat.job_identifier};
          queue_fill++;
          jobs_created = jobs_created + 16'd1;
          res.push_accepted = 1'b1;
          res.quota_done = (jobs_created >= job_quota);
        end
      end
      OP_POP: begin
        if (jobs_completed >= job_quota) begin
          res.quota_done = 1'b1;
        end else if (queue_fill > 0) begin
          best = 0;
          for (idx = 1; idx < queue_fill; idx++) begin
            if (job_store[idx].prio > job_store[best].prio) best = idx;
          end
          res.job_valid = 1'b1;
          res.out_priority = job_store[best].prio;
          res.out_compute_time = job_store[best].ctime;
          res.out_producer = job_store[best].prod;
          res.out_job_id = job_store[best].id;
          queue_fill--;
          for (idx = best; idx < queue_fill; idx++) job_store[idx] = job_store[idx + 1];
        end
      end
      OP_DONE: begin
        if (jobs_completed >= job_quota) begin
          res.quota_done = 1'b1;
        end else begin
          jobs_completed = jobs_completed + 16'd1;
          res.quota_done = (jobs_completed >= job_quota);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = 4'(queue_fill);
    res.created_count = jobs_created;
    res.completed_count = jobs_completed;
    return res;
  endfunction

  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t job_beat(op_e op, logic [3:0] prio, logic [3:0] ctime,
                                        logic [7:0] prod, logic [16:0] id);
    in_item_t beat;
    beat.operation = op;
    beat.job_priority = prio;
    beat.job_compute_time = ctime;
    beat.producer_number = prod;
    beat.job_identifier = id;
    return beat;
  endfunction

  function automatic in_item_t random_job_beat(int push_pct, int pop_pct);
    in_item_t beat;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) beat.operation = OP_PUSH;
    else if (roll < push_pct + pop_pct) beat.operation = OP_POP;
    else if (roll < 92) beat.operation = OP_DONE;
    else beat.operation = OP_NOP;
    beat.job_priority = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(6, 8));
    beat.job_compute_time = 4'($urandom_range(0, 15));
    beat.producer_number = 8'($urandom_range(0, 255));
    beat.job_identifier = 17'($urandom_range(0, 131071));
    return beat;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic write_quota(logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    job_quota = value;
  endtask

  task automatic settle_queue();
    while (pending_beats.size() != 0 || expected_results.size() != 0 || in_bus.valid) begin
      @(negedge clk);
    end
    repeat (12) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(schedule_job_step(in_bus.payload));
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
        if (drain_hold) begin
          in_bus.valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_bus.payload <= pending_beats.pop_front();
          in_bus.valid <= 1'b1;
          send_gap = pick_gap(source_calm);
          if ($urandom_range(0, 149) == 0) drain_hold = 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, expected none actual %0h",
                   $time, out_bus.payload);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("push_accepted", 32'(oldest_result.push_accepted),
                      32'(out_bus.payload.push_accepted));
          check_field("job_valid", 32'(oldest_result.job_valid),
                      32'(out_bus.payload.job_valid));
          check_field("quota_done", 32'(oldest_result.quota_done),
                      32'(out_bus.payload.quota_done));
          check_field("out_priority", 32'(oldest_result.out_priority),
                      32'(out_bus.payload.out_priority));
          check_field("out_compute_time", 32'(oldest_result.out_compute_time),
                      32'(out_bus.payload.out_compute_time));
          check_field("out_producer", 32'(oldest_result.out_producer),
                      32'(out_bus.payload.out_producer));
          check_field("out_job_id", 32'(oldest_result.out_job_id),
                      32'(out_bus.payload.out_job_id));
          check_field("occupancy", 32'(oldest_result.occupancy),
                      32'(out_bus.payload.occupancy));
          check_field("created_count", 32'(oldest_result.created_count),
                      32'(out_bus.payload.created_count));
          check_field("completed_count", 32'(oldest_result.completed_count),
                      32'(out_bus.payload.completed_count));
        end
        sink_stall = pick_gap(sink_calm);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int beat_idx;
    int push_pct;
    int pop_pct;
    int floor_count;
    int low_count;
    int pick;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_quota(16'd0);
    pending_beats.push_back(job_beat(OP_PUSH, 4'd9, 4'd9, 8'd9, 17'd9));
    pending_beats.push_back(job_beat(OP_POP, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_DONE, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_NOP, 4'd0, 4'd0, 8'd0, 17'd0));
    settle_queue();

    write_quota(16'hFFFF);
    pending_beats.push_back(job_beat(OP_POP, 4'hF, 4'hF, 8'hFF, 17'h1FFFF));
    pending_beats.push_back(job_beat(OP_NOP, 4'hF, 4'hF, 8'hFF, 17'h1FFFF));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd5, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd15, 4'd15, 8'd255, 17'h1FFFF));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd0, 4'd3, 8'd1, 17'd1));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd15, 4'd1, 8'd2, 17'h10000));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd7, 4'd8, 8'd128, 17'd2));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd5, 4'd9, 8'd3, 17'd3));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd0, 4'd10, 8'd4, 17'd4));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd3, 4'd11, 8'd5, 17'd5));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd9, 4'd12, 8'd6, 17'd6));
    pending_beats.push_back(job_beat(OP_POP, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_POP, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_POP, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_DONE, 4'hF, 4'hF, 8'hFF, 17'h1FFFF));
    pending_beats.push_back(job_beat(OP_DONE, 4'd0, 4'd0, 8'd0, 17'd0));
    settle_queue();

    write_quota(16'd9);
    pending_beats.push_back(job_beat(OP_PUSH, 4'd12, 4'd2, 8'd77, 17'd1234));
    pending_beats.push_back(job_beat(OP_PUSH, 4'd13, 4'd3, 8'd78, 17'd1235));
    settle_queue();

    write_quota(16'd1);
    pending_beats.push_back(job_beat(OP_POP, 4'd0, 4'd0, 8'd0, 17'd0));
    pending_beats.push_back(job_beat(OP_DONE, 4'd0, 4'd0, 8'd0, 17'd0));
    settle_queue();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      floor_count = int'((jobs_created > jobs_completed) ? jobs_created : jobs_completed);
      low_count = int'((jobs_created < jobs_completed) ? jobs_created : jobs_completed);
      pick = $urandom_range(0, 9);
      if (pick == 0) write_quota(16'hFFFF);
      else if (pick == 1) write_quota(16'($urandom_range(0, low_count)));
      else write_quota(16'(floor_count + $urandom_range(10, 150)));
      push_pct = $urandom_range(30, 50);
      pop_pct = $urandom_range(25, 40);
      for (beat_idx = 0; beat_idx < BEATS_PER_PHASE; beat_idx++) begin
        pending_beats.push_back(random_job_beat(push_pct, pop_pct));
      end
      settle_queue();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
